>>> src/avd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avd_pkg
// Shared types and constants for the stereo volume and differential DAC block.
// ----------------------------------------------------------------------------
package avd_pkg;

    // Configuration register indexes.
    localparam logic REG_OUTPUT_MODE = 1'b0;
    localparam logic REG_VOLUME      = 1'b1;

    // Output modes.
    localparam logic MODE_DIFF_SPK = 1'b0;
    localparam logic MODE_EXT_DAC  = 1'b1;

    // Volume limits and reset value.
    localparam logic [6:0] VOL_MAX   = 7'd100;
    localparam logic [6:0] VOL_RESET = 7'd50;

    // Full-scale speaker swing applied to the mono sample.
    localparam logic [7:0] SPK_MAG = 8'd254;
    localparam logic [14:0] SPK_GAIN_RESET = 15'd12700;

    // Divide by 25 through a reciprocal multiply; the numerator of the speaker
    // path stays below 2^13 and that of the DAC path below 2^20.
    localparam logic [13:0] SPK_RECIP = 14'd10486;
    localparam logic [20:0] DAC_RECIP = 21'd1342178;

    // Leg limit and mid-scale bias of the differential pair.
    localparam logic [7:0] LEG_LIM = 8'd127;
    localparam logic [8:0] LEG_MID = 9'd128;

    // Register values seen by the datapath.
    typedef struct packed {
        logic        mode;
        logic [6:0]  volume;
        logic [14:0] spk_gain;
    } avd_cfg_t;

    // Load enables of the three datapath stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } avd_stage_en_t;

endpackage

>>> src/avd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avd_cfg_regs
// Output mode and volume registers, with the speaker gain kept precomputed.
// ----------------------------------------------------------------------------
module avd_cfg_regs
    import avd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data,
    output avd_cfg_t   cfg
);

    logic        mode_reg;
    logic        mode_next;
    logic [6:0]  volume_reg;
    logic [6:0]  volume_next;
    logic [14:0] gain_reg;
    logic [14:0] gain_next;
    logic [6:0]  volume_clamped;

    // A volume above full scale is stored as full scale.
    assign volume_clamped = (cfg_data > VOL_MAX) ? VOL_MAX : cfg_data;

    // Register writes.
    always_comb
    begin
        mode_next   = mode_reg;
        volume_next = volume_reg;
        gain_next   = gain_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_OUTPUT_MODE:
                begin
                    mode_next = cfg_data[0];
                end
                REG_VOLUME:
                begin
                    volume_next = volume_clamped;
                    gain_next   = 15'({8'd0, volume_clamped} * {7'd0, SPK_MAG});
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_DIFF_SPK;
            volume_reg <= VOL_RESET;
            gain_reg   <= SPK_GAIN_RESET;
        end
        else
        begin
            mode_reg   <= mode_next;
            volume_reg <= volume_next;
            gain_reg   <= gain_next;
        end
    end

    assign cfg.mode     = mode_reg;
    assign cfg.volume   = volume_reg;
    assign cfg.spk_gain = gain_reg;

endmodule

>>> src/avd_spk_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avd_spk_lane
// Speaker path: mono downmix, volume scaling and split into two biased legs.
// ----------------------------------------------------------------------------
module avd_spk_lane
    import avd_pkg::*;
(
    input  logic               clk,
    input  avd_stage_en_t      en,
    input  logic signed [15:0] a,
    input  logic signed [15:0] b,
    input  logic [14:0]        gain,
    output logic [7:0]         pos_leg,
    output logic [7:0]         neg_leg
);

    logic [16:0] sum;
    logic [15:0] avg;
    logic [15:0] avg_mag;

    logic [29:0] s1_prod_reg;
    logic [29:0] s1_prod_next;
    logic        s1_neg_reg;

    logic [26:0] recip_prod;
    logic [7:0]  s2_quot_reg;
    logic [7:0]  s2_quot_next;
    logic        s2_neg_reg;

    logic [7:0]  excess;
    logic [8:0]  pos_wide;
    logic [8:0]  neg_wide;
    logic [7:0]  s3_pos_reg;
    logic [7:0]  s3_neg_reg;

    // Stage 1: average by arithmetic shift, then magnitude times gain.
    assign sum          = {a[15], a} + {b[15], b};
    assign avg          = sum[16:1];
    assign avg_mag      = avg[15] ? 16'(~avg + 16'd1) : avg;
    assign s1_prod_next = 30'({15'd0, avg_mag} * {16'd0, gain});

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            s1_prod_reg <= s1_prod_next;
            s1_neg_reg  <= avg[15];
        end
    end

    // Stage 2: divide by 2^17 by shift, then by 25 by reciprocal multiply.
    assign recip_prod   = {14'd0, s1_prod_reg[29:17]} * {13'd0, SPK_RECIP};
    assign s2_quot_next = recip_prod[25:18];

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            s2_quot_reg <= s2_quot_next;
            s2_neg_reg  <= s1_neg_reg;
        end
    end

    // Stage 3: saturate the positive leg and move the excess to the negative leg.
    assign excess = s2_quot_reg - LEG_LIM;

    always_comb
    begin
        if (s2_quot_reg > LEG_LIM)
        begin
            if (s2_neg_reg)
            begin
                pos_wide = 9'd1;
                neg_wide = LEG_MID + {1'b0, excess};
            end
            else
            begin
                pos_wide = 9'd255;
                neg_wide = LEG_MID - {1'b0, excess};
            end
        end
        else
        begin
            pos_wide = s2_neg_reg ? (LEG_MID - {1'b0, s2_quot_reg})
                                  : (LEG_MID + {1'b0, s2_quot_reg});
            neg_wide = LEG_MID;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            s3_pos_reg <= pos_wide[7:0];
            s3_neg_reg <= neg_wide[7:0];
        end
    end

    assign pos_leg = s3_pos_reg;
    assign neg_leg = s3_neg_reg;

endmodule

>>> src/avd_dac_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avd_dac_lane
// External DAC path for one channel: sample times volume divided by 100.
// ----------------------------------------------------------------------------
module avd_dac_lane
    import avd_pkg::*;
(
    input  logic               clk,
    input  avd_stage_en_t      en,
    input  logic signed [15:0] sample,
    input  logic [6:0]         volume,
    output logic [15:0]        word
);

    logic [15:0] mag;
    logic [21:0] s1_prod_reg;
    logic [21:0] s1_prod_next;
    logic        s1_neg_reg;

    logic [30:0] s2_lo_reg;
    logic [30:0] s2_lo_next;
    logic [30:0] s2_hi_reg;
    logic [30:0] s2_hi_next;
    logic        s2_neg_reg;

    logic [40:0] full;
    logic [15:0] s3_quot_reg;
    logic        s3_neg_reg;

    // Stage 1: magnitude times volume; truncation toward zero works on magnitudes.
    assign mag          = sample[15] ? 16'(~sample + 16'sd1) : 16'(sample);
    assign s1_prod_next = 22'({7'd0, mag} * {16'd0, volume});

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            s1_prod_reg <= s1_prod_next;
            s1_neg_reg  <= sample[15];
        end
    end

    // Stage 2: divide by 4 by shift; the multiply by the reciprocal of 25 is
    // split into two partial products on the low and high halves.
    assign s2_lo_next = {21'd0, s1_prod_reg[11:2]} * {10'd0, DAC_RECIP};
    assign s2_hi_next = {21'd0, s1_prod_reg[21:12]} * {10'd0, DAC_RECIP};

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            s2_lo_reg  <= s2_lo_next;
            s2_hi_reg  <= s2_hi_next;
            s2_neg_reg <= s1_neg_reg;
        end
    end

    // Stage 3: combine the partial products and take the quotient.
    assign full = {s2_hi_reg, 10'd0} + {10'd0, s2_lo_reg};

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            s3_quot_reg <= full[40:25];
            s3_neg_reg  <= s2_neg_reg;
        end
    end

    // Restore the sign; the magnitude never exceeds 32768.
    assign word = s3_neg_reg ? 16'(~s3_quot_reg + 16'd1) : s3_quot_reg;

endmodule

>>> src/audio_volume_differential_dac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_volume_differential_dac
// Stereo frame volume stage for a differential speaker DAC or an external DAC.
//
// Usage:
// One frame (first_sample, second_sample, frame_last) is a transaction on the
// input channel (in_valid, in_stall); one result (first_word, second_word,
// last) is a transaction on the output channel (out_valid, out_stall).
// In speaker mode the frame is mixed to mono, scaled by volume and split into
// a positive leg and a negative leg around mid-scale. In external DAC mode
// each sample is scaled by volume on its own.
// The pipeline has five register stages: input, three datapath stages and
// the output register. Throughput is one frame per cycle, set by the
// pipelined multipliers, as long as no output stall holds the pipeline.
// A stall on the output holds the output register; each stage still fills
// while the stage after it is empty, so the input stalls only once every
// stage holds a frame.
// Reset empties the pipeline and sets speaker mode and a volume of 50.
// Configuration is written through cfg_write_en, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module audio_volume_differential_dac
    import avd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] first_sample,
    input  logic signed [15:0] second_sample,
    input  logic               frame_last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        first_word,
    output logic [15:0]        second_word,
    output logic               last
);

    avd_cfg_t      cfg;
    avd_stage_en_t en;

    logic v0_reg;
    logic v0_next;
    logic v1_reg;
    logic v1_next;
    logic v2_reg;
    logic v2_next;
    logic v3_reg;
    logic v3_next;
    logic ov_reg;
    logic ov_next;
    logic rdy0;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy_out;

    logic signed [15:0] a_reg;
    logic signed [15:0] b_reg;
    logic               last0_reg;
    logic               last1_reg;
    logic               last2_reg;
    logic               last3_reg;
    logic [15:0]        first_word_reg;
    logic [15:0]        first_word_next;
    logic [15:0]        second_word_reg;
    logic [15:0]        second_word_next;
    logic               last_out_reg;

    logic [7:0]  pos_leg;
    logic [7:0]  neg_leg;
    logic [15:0] dac_first;
    logic [15:0] dac_second;

    avd_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    // A stage takes new data when it is empty or the stage after it moves on.
    assign rdy_out  = !ov_reg || !out_stall;
    assign rdy3     = !v3_reg || rdy_out;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign in_stall = !rdy0;

    assign en.s1 = rdy1 && v0_reg;
    assign en.s2 = rdy2 && v1_reg;
    assign en.s3 = rdy3 && v2_reg;

    // Valid bits of the pipeline.
    always_comb
    begin
        v0_next = rdy0    ? in_valid : v0_reg;
        v1_next = rdy1    ? v0_reg   : v1_reg;
        v2_next = rdy2    ? v1_reg   : v2_reg;
        v3_next = rdy3    ? v2_reg   : v3_reg;
        ov_next = rdy_out ? v3_reg   : ov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            ov_reg <= ov_next;
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (in_valid && rdy0)
        begin
            a_reg     <= first_sample;
            b_reg     <= second_sample;
            last0_reg <= frame_last;
        end
    end

    // End-of-buffer mark travels beside the datapath.
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            last1_reg <= last0_reg;
        end
        if (en.s2)
        begin
            last2_reg <= last1_reg;
        end
        if (en.s3)
        begin
            last3_reg <= last2_reg;
        end
    end

    avd_spk_lane u_spk (
        .clk     (clk),
        .en      (en),
        .a       (a_reg),
        .b       (b_reg),
        .gain    (cfg.spk_gain),
        .pos_leg (pos_leg),
        .neg_leg (neg_leg)
    );

    avd_dac_lane u_dac_first (
        .clk    (clk),
        .en     (en),
        .sample (a_reg),
        .volume (cfg.volume),
        .word   (dac_first)
    );

    avd_dac_lane u_dac_second (
        .clk    (clk),
        .en     (en),
        .sample (b_reg),
        .volume (cfg.volume),
        .word   (dac_second)
    );

    // Output selection by mode.
    always_comb
    begin
        case (cfg.mode)
            MODE_EXT_DAC:
            begin
                first_word_next  = dac_first;
                second_word_next = dac_second;
            end
            default:
            begin
                first_word_next  = {neg_leg, 8'd0};
                second_word_next = {pos_leg, 8'd0};
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (rdy_out && v3_reg)
        begin
            first_word_reg  <= first_word_next;
            second_word_reg <= second_word_next;
            last_out_reg    <= last3_reg;
        end
    end

    assign out_valid   = ov_reg;
    assign first_word  = first_word_reg;
    assign second_word = second_word_reg;
    assign last        = last_out_reg;

endmodule

>>> tb/volume_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_frame_checker
// Watches the configuration port and both channels of the volume stage. For
// each frame transaction it computes the expected output words from its own
// copy of the mode and volume registers. It then compares each result
// transaction, field by field, with the oldest expected words.
// ----------------------------------------------------------------------------
module volume_frame_checker
    import avd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] first_sample,
    input  logic signed [15:0] second_sample,
    input  logic               frame_last,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [15:0]        first_word,
    input  logic [15:0]        second_word,
    input  logic               last,
    output int unsigned        mismatch_count,
    output int unsigned        words_due
);

    // Speaker scaling is 254 * (avg / 32768) * (volume / 100).
    localparam longint SPEAKER_SWING   = 254;
    localparam longint SPEAKER_DIVISOR = 3276800;
    localparam longint LEG_LIMIT       = 127;
    localparam longint LEG_BIAS        = 128;
    localparam longint PERCENT         = 100;
    localparam longint WORD_MAX        = 32767;
    localparam longint WORD_MIN        = -32768;

    typedef struct packed {
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic        last;
    } frame_words_t;

    logic         mode_q;
    logic [6:0]   volume_q;
    frame_words_t expected_words_q[$];

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        $display("%0t ns: checker: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Scales one sample by the volume for the external DAC, with saturation.
    function automatic logic [15:0] dac_word(input logic signed [15:0] sample);
        longint scaled;
        scaled = (longint'(sample) * longint'(volume_q)) / PERCENT;
        if (scaled > WORD_MAX)
        begin
            scaled = WORD_MAX;
        end
        if (scaled < WORD_MIN)
        begin
            scaled = WORD_MIN;
        end
        return 16'(scaled);
    endfunction

    // Works out the output words of one frame under the current registers.
    function automatic frame_words_t scale_frame(input logic signed [15:0] a,
                                                 input logic signed [15:0] b,
                                                 input logic mark);
        frame_words_t       words;
        logic signed [16:0] sum;
        logic signed [16:0] mono;
        longint             level;
        longint             pos_leg;
        longint             neg_leg;
        words.last = mark;
        if (mode_q == MODE_DIFF_SPK)
        begin
            sum   = 17'(a) + 17'(b);
            mono  = sum >>> 1;
            level = (longint'(mono) * SPEAKER_SWING * longint'(volume_q)) / SPEAKER_DIVISOR;
            // The positive leg saturates and the excess moves to the negative leg.
            if (level > LEG_LIMIT)
            begin
                pos_leg = LEG_LIMIT;
                neg_leg = level - LEG_LIMIT;
            end
            else if (level < -LEG_LIMIT)
            begin
                pos_leg = -LEG_LIMIT;
                neg_leg = level + LEG_LIMIT;
            end
            else
            begin
                pos_leg = level;
                neg_leg = 0;
            end
            pos_leg = pos_leg + LEG_BIAS;
            neg_leg = LEG_BIAS - neg_leg;
            words.first_word  = 16'(neg_leg * 256);
            words.second_word = 16'(pos_leg * 256);
        end
        else
        begin
            words.first_word  = dac_word(a);
            words.second_word = dac_word(b);
        end
        return words;
    endfunction

    // Register copy, expectation store and result comparison.
    always @(posedge clk or negedge rst_n)
    begin
        frame_words_t want;
        if (!rst_n)
        begin
            mode_q   = MODE_DIFF_SPK;
            volume_q = VOL_RESET;
            expected_words_q.delete();
            words_due <= 0;
        end
        else
        begin
            // A result transaction is matched against the oldest expectation.
            if (out_valid && !out_stall)
            begin
                if (expected_words_q.size() == 0)
                begin
                    report_mismatch($sformatf("result %04h %04h %0b with nothing expected",
                                              first_word, second_word, last));
                end
                else
                begin
                    want = expected_words_q.pop_front();
                    if (first_word !== want.first_word)
                    begin
                        report_mismatch($sformatf("first_word got %04h expected %04h",
                                                  first_word, want.first_word));
                    end
                    if (second_word !== want.second_word)
                    begin
                        report_mismatch($sformatf("second_word got %04h expected %04h",
                                                  second_word, want.second_word));
                    end
                    if (last !== want.last)
                    begin
                        report_mismatch($sformatf("last got %0b expected %0b",
                                                  last, want.last));
                    end
                end
            end

            // A frame transaction adds its expected words.
            if (in_valid && !in_stall)
            begin
                expected_words_q.push_back(scale_frame(first_sample, second_sample,
                                                       frame_last));
            end

            // Register writes; the volume saturates at its maximum.
            if (cfg_write_en)
            begin
                if (cfg_index == REG_OUTPUT_MODE)
                begin
                    mode_q = cfg_data[0];
                end
                else
                begin
                    volume_q = (cfg_data > VOL_MAX) ? VOL_MAX : cfg_data;
                end
            end

            words_due <= expected_words_q.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives frames and register writes into the stereo volume stage with random
// gaps on the input and random stalls on the output, and gives the verdict.
// A short directed part covers the sample extremes, both modes, zero and full
// volume and an out-of-range volume write. Random phases follow, each under
// its own register setting. The checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_top
    import avd_pkg::*;
();

    localparam int RANDOM_PHASES    = 10;
    localparam int FRAMES_PER_PHASE = 153;
    localparam int MAX_WAIT         = 8;
    localparam int LONG_HOLD_CYCLES = 240;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 12;
    localparam int SOURCE           = 0;
    localparam int SINK             = 1;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_write_en  = 1'b0;
    logic               cfg_index     = REG_OUTPUT_MODE;
    logic [6:0]         cfg_data      = 7'd0;
    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic signed [15:0] first_sample  = 16'sd0;
    logic signed [15:0] second_sample = 16'sd0;
    logic               frame_last    = 1'b0;
    logic               out_valid;
    logic               out_stall     = 1'b0;
    logic [15:0]        first_word;
    logic [15:0]        second_word;
    logic               last;

    int unsigned mismatch_count;
    int unsigned words_due;
    int          quiet_cycles = 0;
    bit          hold_req     = 1'b0;
    int          run_left[2]  = '{0, 0};
    bit          no_idle[2]   = '{1'b0, 1'b0};

    audio_volume_differential_dac i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .first_sample (first_sample),
        .second_sample(second_sample),
        .frame_last   (frame_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .first_word   (first_word),
        .second_word  (second_word),
        .last         (last)
    );

    volume_frame_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .first_sample  (first_sample),
        .second_sample (second_sample),
        .frame_last    (frame_last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .first_word    (first_word),
        .second_word   (second_word),
        .last          (last),
        .mismatch_count(mismatch_count),
        .words_due     (words_due)
    );

    // Clock with a 2 ns period.
    always #1 clk = ~clk;

    // Wait cycles per transaction, in runs that either idle at random or not at all.
    function automatic int draw_wait(input int side);
        if (run_left[side] == 0)
        begin
            run_left[side] = $urandom_range(10, 50);
            no_idle[side]  = ($urandom_range(0, 3) == 0);
        end
        run_left[side]--;
        return no_idle[side] ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Samples weighted toward the extremes and toward zero.
    function automatic logic signed [15:0] draw_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'(int'($urandom_range(0, 511)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // The second sample is sometimes tied to the first to reach full swing.
    function automatic logic signed [15:0] draw_partner(input logic signed [15:0] a);
        case ($urandom_range(0, 5))
            0:       return a;
            1:       return 16'(-a);
            default: return draw_sample();
        endcase
    endfunction

    // Volume writes, including zero, full scale and values that saturate.
    function automatic logic [6:0] draw_volume();
        case ($urandom_range(0, 5))
            0:       return 7'd0;
            1:       return VOL_MAX;
            2:       return 7'($urandom_range(101, 127));
            3:       return 7'd1;
            default: return 7'($urandom_range(0, 100));
        endcase
    endfunction

    // Offers one frame after a random gap and holds it until it is taken.
    task automatic send_frame(input logic signed [15:0] a, input logic signed [15:0] b,
                              input logic mark);
        int gap;
        gap = draw_wait(SOURCE);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        first_sample  <= a;
        second_sample <= b;
        frame_last    <= mark;
        do @(posedge clk); while (in_stall);
    endtask

    // Stops offering and waits until every expected result has arrived.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (words_due != 0);
    endtask

    // Writes both registers while the block is idle; the mode write carries
    // random upper data bits, which the block must ignore.
    task automatic set_config(input logic mode, input logic [6:0] volume);
        wait_idle();
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_OUTPUT_MODE;
        cfg_data     <= {6'($urandom), mode};
        @(posedge clk);
        cfg_index    <= REG_VOLUME;
        cfg_data     <= volume;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Output side: a random stall per result, and one long hold on request.
    initial
    begin: result_sink
        int stall_cycles;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall_cycles = hold_req ? LONG_HOLD_CYCLES : draw_wait(SINK);
            hold_req     = 1'b0;
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Watchdog: ends the run when no transaction happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Stimulus and verdict.
    initial
    begin: stimulus
        int                 phase_idx;
        int                 frame_idx;
        logic signed [15:0] a_sample;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: speaker mode at half volume, with the rounding of
        // the arithmetic shift on odd negative sums.
        send_frame(16'sd0, 16'sd0, 1'b0);
        send_frame(16'sh7fff, 16'sh7fff, 1'b1);
        send_frame(16'sh8000, 16'sh8000, 1'b0);
        send_frame(16'sh7fff, 16'sh8000, 1'b0);
        send_frame(-16'sd1, 16'sd0, 1'b1);
        send_frame(16'sd1, 16'sd0, 1'b0);

        // Volume write above range saturates to full scale; both legs saturate.
        set_config(MODE_DIFF_SPK, 7'd127);
        send_frame(16'sh7fff, 16'sh7fff, 1'b0);
        send_frame(16'sh8000, 16'sh8000, 1'b1);
        send_frame(16'sd16384, 16'sd16384, 1'b0);
        send_frame(16'sh7fff, 16'sd0, 1'b0);
        send_frame(-16'sd3, 16'sd0, 1'b0);

        // External DAC at full volume.
        set_config(MODE_EXT_DAC, VOL_MAX);
        send_frame(16'sh7fff, 16'sh8000, 1'b1);
        send_frame(-16'sd1, 16'sd1, 1'b0);
        send_frame(16'sd12345, -16'sd12345, 1'b0);

        // Volume zero in both modes: speaker words sit at mid-scale.
        set_config(MODE_EXT_DAC, 7'd0);
        send_frame(16'sh7fff, 16'sh8000, 1'b0);
        send_frame(-16'sd100, 16'sd100, 1'b1);
        set_config(MODE_DIFF_SPK, 7'd0);
        send_frame(16'sh7fff, 16'sh7fff, 1'b0);
        send_frame(16'sh8000, 16'sh8000, 1'b1);

        // Lowest nonzero volume in both modes.
        set_config(MODE_EXT_DAC, 7'd1);
        send_frame(16'sh7fff, 16'sh8000, 1'b0);
        send_frame(-16'sd99, 16'sd99, 1'b0);
        set_config(MODE_DIFF_SPK, 7'd1);
        send_frame(16'sh8000, 16'sh8000, 1'b1);
        send_frame(16'sh7fff, 16'sh7fff, 1'b0);

        // Random phases, alternating modes; the first two at full volume.
        for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++)
        begin
            set_config(1'(phase_idx % 2), (phase_idx < 2) ? VOL_MAX : draw_volume());
            // Long output hold while frames keep coming, so the pipeline fills.
            if (phase_idx == 3)
            begin
                hold_req = 1'b1;
            end
            for (frame_idx = 0; frame_idx < FRAMES_PER_PHASE; frame_idx++)
            begin
                // Pause mid-phase until the pipeline has drained.
                if (phase_idx == 6 && frame_idx == FRAMES_PER_PHASE / 2)
                begin
                    wait_idle();
                end
                a_sample = draw_sample();
                send_frame(a_sample, draw_partner(a_sample), $urandom_range(0, 7) == 0);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && words_due == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
src/avd_pkg.sv
src/avd_cfg_regs.sv
src/avd_spk_lane.sv
src/avd_dac_lane.sv
src/audio_volume_differential_dac.sv
tb/volume_frame_checker.sv
tb/tb_top.sv
